// ===== rtl/pcvd_pkg.sv =====
// Package for the variable time step PID controller.
// Holds widths, constants, register indexes, sequencer states and the configuration type.
// No dependencies.
package pcvd_pkg;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned TimeBits  = 48;
  localparam int unsigned DataW     = 32;
  localparam int unsigned ErrW      = 33;
  localparam int unsigned DeltaW    = 34;
  localparam int unsigned AccW      = 64;
  localparam int unsigned MulAW     = 33;
  localparam int unsigned MulBW     = 64;
  localparam int unsigned MulPW     = MulAW + MulBW;
  localparam int unsigned SumW      = MulPW + 2;
  localparam int unsigned CntW      = 6;
  localparam int unsigned AddrW     = 5;

  localparam logic [63:0] NsPerS    = 64'd1000000000;
  localparam logic [63:0] HalfNs    = 64'd500000000;

  localparam logic [DataW-1:0] GainPRst  = 32'd26214;
  localparam logic [DataW-1:0] GainIRst  = 32'd19661;
  localparam logic [DataW-1:0] GainDRst  = 32'd52429;
  localparam logic [DataW-1:0] TargetRst = 32'd0;
  localparam logic [DataW-1:0] OutMinRst = 32'hFF9C0000;
  localparam logic [DataW-1:0] OutMaxRst = 32'h00640000;

  typedef enum logic [2:0] {
    REG_GAIN_P  = 3'd0,
    REG_GAIN_I  = 3'd1,
    REG_GAIN_D  = 3'd2,
    REG_TARGET  = 3'd3,
    REG_OUT_MIN = 3'd4,
    REG_OUT_MAX = 3'd5,
    REG_SPARE6  = 3'd6,
    REG_SPARE7  = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_DT,
    ST_MUL_PART,
    ST_DIV_FRAC,
    ST_MUL_WHOLE,
    ST_MUL_DM,
    ST_DIV_DER,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic signed [DataW-1:0] gain_p;
    logic signed [DataW-1:0] gain_i;
    logic signed [DataW-1:0] gain_d;
    logic signed [DataW-1:0] target;
    logic signed [DataW-1:0] out_min;
    logic signed [DataW-1:0] out_max;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

endpackage

// ===== rtl/pcvd_if.sv =====
// Valid/ready channels for the PID controller: input tick and output drive.
// Depends on pcvd_pkg.
interface pcvd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pcvd_pkg::DataW-1:0]    measured_angle;
  logic        [pcvd_pkg::TimeBits-1:0] time_ns;
  modport source (output valid, measured_angle, time_ns, input ready);
  modport sink (input valid, measured_angle, time_ns, output ready);
endinterface

interface pcvd_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [pcvd_pkg::DataW-1:0] drive;
  logic                              clamped;
  modport source (output valid, drive, clamped, input ready);
  modport sink (input valid, drive, clamped, output ready);
endinterface

// ===== rtl/pid_controller_variable_dt.sv =====
// PID controller with variable time step: one item is in work at a time, and every arithmetic
// step runs on a bit-serial unit (launch, iterations, hand-back). A tick with a positive time
// step runs nine passes (three divisions, three multiplications for the integral and derivative
// terms, three gain products) between taking the input item and presenting its result, and the
// next input item can be taken in the same cycle as that result is presented; the first tick or
// one without time advance runs the three gain products only.
// A result still waiting at the output holds the sequencer in its last state until it is taken.
// Depends on pcvd_pkg, pcvd_if, pcvd_regs, pcvd_mul and pcvd_div.
module pid_controller_variable_dt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pcvd_pkg::AddrW-1:0]  paddr,
  input  logic [pcvd_pkg::DataW-1:0]  pwdata,
  output logic [pcvd_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  pcvd_in_if.sink                     in_if,
  pcvd_out_if.source                  out_if
);
  import pcvd_pkg::*;

  cfg_t      cfg;
  state_e    state_q, state_d;
  logic      launch_q;
  unit_ctl_t mul_ctl, div_ctl;

  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] mul_p;
  logic [63:0]      div_n, div_d, div_q, div_r;

  logic signed [AccW-1:0]    integral_q;
  logic signed [ErrW-1:0]    last_err_q, e_q, e_new;
  logic [TimeBits-1:0]       last_time_q, dt_q;
  logic                      first_q;
  logic signed [DeltaW-1:0]  de_q;
  logic [TimeBits-1:0]       quo_q;
  logic [29:0]               rem_q;
  logic [DeltaW-1:0]         frac_q;
  logic signed [AccW-1:0]    deriv_q;
  logic signed [SumW-1:0]    sum_q;

  logic [MulAW-1:0] e_mag;
  logic [63:0]      de_mag, i_mag, d_mag;
  logic [DataW-1:0] g_mag;
  logic             g_neg, v_neg;
  logic signed [SumW-1:0] prod_s;
  logic [63:0]      m_inc;
  logic signed [AccW:0] i_add, i_sub;
  logic [63:0]      d_rnd;
  logic [63:0]      d_sat;
  logic signed [SumW-1:0] rnd_sum;
  logic signed [SumW-FracBits-1:0] shr;
  logic             unit_done;
  logic             unit_is_mul;
  logic             in_acc, out_free;

  logic                     out_valid_q;
  logic signed [DataW-1:0]  drive_q;
  logic                     clamped_q;

  pcvd_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  pcvd_mul u_mul (
    .clk_i, .rst_ni, .start_i (mul_ctl.start), .a_i (mul_a), .b_i (mul_b),
    .done_o (mul_ctl.done), .p_o (mul_p)
  );

  pcvd_div u_div (
    .clk_i, .rst_ni, .start_i (div_ctl.start), .n_i (div_n), .d_i (div_d),
    .done_o (div_ctl.done), .q_o (div_q), .r_o (div_r)
  );

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_q || out_if.ready;
  assign out_if.valid   = out_valid_q;
  assign out_if.drive   = drive_q;
  assign out_if.clamped = clamped_q;

  assign e_new  = ErrW'(cfg.target) - ErrW'(in_if.measured_angle);
  assign e_mag  = e_q[ErrW-1] ? MulAW'(-e_q) : MulAW'(e_q);
  assign de_mag = de_q[DeltaW-1] ? 64'(-de_q) : 64'(de_q);
  assign i_mag  = integral_q[AccW-1] ? 64'(-integral_q) : 64'(integral_q);
  assign d_mag  = deriv_q[AccW-1] ? 64'(-deriv_q) : 64'(deriv_q);

  always_comb begin
    g_mag = '0;
    g_neg = 1'b0;
    v_neg = 1'b0;
    mul_a = '0;
    mul_b = '0;
    div_n = '0;
    div_d = NsPerS;
    unique case (state_q)
      ST_MUL_PART: begin
        mul_a = e_mag;
        mul_b = 64'(rem_q);
      end
      ST_MUL_WHOLE: begin
        mul_a = e_mag;
        mul_b = 64'(quo_q);
      end
      ST_MUL_DM: begin
        mul_a = MulAW'(NsPerS);
        mul_b = de_mag;
      end
      ST_MUL_P: begin
        g_neg = cfg.gain_p[DataW-1];
        g_mag = g_neg ? DataW'(-cfg.gain_p) : cfg.gain_p;
        v_neg = e_q[ErrW-1];
        mul_a = MulAW'(g_mag);
        mul_b = 64'(e_mag);
      end
      ST_MUL_I: begin
        g_neg = cfg.gain_i[DataW-1];
        g_mag = g_neg ? DataW'(-cfg.gain_i) : cfg.gain_i;
        v_neg = integral_q[AccW-1];
        mul_a = MulAW'(g_mag);
        mul_b = i_mag;
      end
      ST_MUL_D: begin
        g_neg = cfg.gain_d[DataW-1];
        g_mag = g_neg ? DataW'(-cfg.gain_d) : cfg.gain_d;
        v_neg = deriv_q[AccW-1];
        mul_a = MulAW'(g_mag);
        mul_b = d_mag;
      end
      ST_DIV_DT: div_n = 64'(dt_q);
      ST_DIV_FRAC: div_n = mul_p[63:0] + HalfNs;
      ST_DIV_DER: begin
        div_n = mul_p[63:0];
        div_d = 64'(dt_q);
      end
      default: ;
    endcase
  end

  assign unit_is_mul   = (state_q == ST_MUL_PART || state_q == ST_MUL_WHOLE ||
                          state_q == ST_MUL_DM || state_q == ST_MUL_P ||
                          state_q == ST_MUL_I || state_q == ST_MUL_D);
  assign mul_ctl.start = launch_q && unit_is_mul;
  assign div_ctl.start = launch_q && (state_q == ST_DIV_DT || state_q == ST_DIV_FRAC ||
                         state_q == ST_DIV_DER);
  assign unit_done = !launch_q && (unit_is_mul ? mul_ctl.done : div_ctl.done);

  assign prod_s = (g_neg != v_neg) ? -SumW'(mul_p) : SumW'(mul_p);
  assign m_inc  = mul_p[63:0] + 64'(frac_q);
  assign i_add  = {integral_q[AccW-1], integral_q} + {1'b0, m_inc};
  assign i_sub  = {integral_q[AccW-1], integral_q} - {1'b0, m_inc};
  assign d_rnd  = (div_r >= (div_d - div_r)) ? div_q + 64'd1 : div_q;
  assign d_sat  = d_rnd[63] ? {1'b0, {63{1'b1}}} : d_rnd;
  assign rnd_sum = sum_q + (SumW'(1) <<< (FracBits - 1));
  assign shr     = rnd_sum[SumW-1:FracBits];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) begin
        state_d = (!first_q && in_if.time_ns > last_time_q) ? ST_DIV_DT : ST_MUL_P;
      end
      ST_DIV_DT:    if (unit_done) state_d = ST_MUL_PART;
      ST_MUL_PART:  if (unit_done) state_d = ST_DIV_FRAC;
      ST_DIV_FRAC:  if (unit_done) state_d = ST_MUL_WHOLE;
      ST_MUL_WHOLE: if (unit_done) state_d = ST_MUL_DM;
      ST_MUL_DM:    if (unit_done) state_d = ST_DIV_DER;
      ST_DIV_DER:   if (unit_done) state_d = ST_MUL_P;
      ST_MUL_P:     if (unit_done) state_d = ST_MUL_I;
      ST_MUL_I:     if (unit_done) state_d = ST_MUL_D;
      ST_MUL_D:     if (unit_done) state_d = ST_FINISH;
      ST_FINISH:    if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
      first_q     <= 1'b1;
      last_time_q <= '0;
      last_err_q  <= '0;
      integral_q  <= '0;
    end else begin
      state_q  <= state_d;
      launch_q <= (state_d != state_q) && (state_d != ST_IDLE);
      if (out_valid_q && out_if.ready) out_valid_q <= 1'b0;
      if (state_q == ST_FINISH && out_free) out_valid_q <= 1'b1;
      if (in_acc) begin
        first_q     <= 1'b0;
        last_time_q <= in_if.time_ns;
        last_err_q  <= e_new;
      end
      if (state_q == ST_MUL_WHOLE && unit_done) begin
        if (!e_q[ErrW-1]) begin
          integral_q <= (i_add[AccW] != i_add[AccW-1]) ? {1'b0, {(AccW-1){1'b1}}}
                                                       : i_add[AccW-1:0];
        end else begin
          integral_q <= (i_sub[AccW] != i_sub[AccW-1]) ? {1'b1, {(AccW-1){1'b0}}}
                                                       : i_sub[AccW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      e_q     <= e_new;
      de_q    <= DeltaW'(e_new) - DeltaW'(last_err_q);
      dt_q    <= in_if.time_ns - last_time_q;
      deriv_q <= '0;
      sum_q   <= '0;
    end
    if (unit_done) begin
      unique case (state_q)
        ST_DIV_DT: begin
          quo_q <= div_q[TimeBits-1:0];
          rem_q <= div_r[29:0];
        end
        ST_DIV_FRAC: frac_q <= div_q[DeltaW-1:0];
        ST_DIV_DER:  deriv_q <= de_q[DeltaW-1] ? -AccW'(d_sat) : AccW'(d_sat);
        ST_MUL_P, ST_MUL_I, ST_MUL_D: sum_q <= sum_q + prod_s;
        default: ;
      endcase
    end
    if (state_q == ST_FINISH && out_free) begin
      if (shr > (SumW-FracBits)'(cfg.out_max)) begin
        drive_q   <= cfg.out_max;
        clamped_q <= 1'b1;
      end else if (shr < (SumW-FracBits)'(cfg.out_min)) begin
        drive_q   <= cfg.out_min;
        clamped_q <= 1'b1;
      end else begin
        drive_q   <= shr[DataW-1:0];
        clamped_q <= 1'b0;
      end
    end
  end
endmodule

// ===== rtl/pcvd_regs.sv =====
// APB configuration registers of the PID controller.
// Depends on pcvd_pkg.
module pcvd_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pcvd_pkg::AddrW-1:0]   paddr,
  input  logic [pcvd_pkg::DataW-1:0]   pwdata,
  output logic [pcvd_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output pcvd_pkg::cfg_t               cfg_o
);
  import pcvd_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p  <= GainPRst;
      cfg_q.gain_i  <= GainIRst;
      cfg_q.gain_d  <= GainDRst;
      cfg_q.target  <= TargetRst;
      cfg_q.out_min <= OutMinRst;
      cfg_q.out_max <= OutMaxRst;
    end else if (wr) begin
      unique case (idx)
        REG_GAIN_P:  cfg_q.gain_p  <= pwdata;
        REG_GAIN_I:  cfg_q.gain_i  <= pwdata;
        REG_GAIN_D:  cfg_q.gain_d  <= pwdata;
        REG_TARGET:  cfg_q.target  <= pwdata;
        REG_OUT_MIN: cfg_q.out_min <= pwdata;
        REG_OUT_MAX: cfg_q.out_max <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GAIN_P:  prdata = cfg_q.gain_p;
      REG_GAIN_I:  prdata = cfg_q.gain_i;
      REG_GAIN_D:  prdata = cfg_q.gain_d;
      REG_TARGET:  prdata = cfg_q.target;
      REG_OUT_MIN: prdata = cfg_q.out_min;
      REG_OUT_MAX: prdata = cfg_q.out_max;
      default:     prdata = '0;
    endcase
  end
endmodule

// ===== rtl/pcvd_mul.sv =====
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on pcvd_pkg.
module pcvd_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [pcvd_pkg::MulAW-1:0]    a_i,
  input  logic [pcvd_pkg::MulBW-1:0]    b_i,
  output logic                          done_o,
  output logic [pcvd_pkg::MulPW-1:0]    p_o
);
  import pcvd_pkg::*;

  logic [MulPW-1:0] p_q, p_d;
  logic [MulAW-1:0] a_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [MulAW:0]   hi_sum;

  assign hi_sum = {1'b0, p_q[MulPW-1:MulBW]} + (p_q[0] ? {1'b0, a_q} : '0);
  assign p_d    = {hi_sum, p_q[MulBW-1:1]};
  assign done_o = done_q;
  assign p_o    = p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == '1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      p_q <= {{MulAW{1'b0}}, b_i};
    end else if (busy_q) begin
      p_q <= p_d;
    end
  end
endmodule

// ===== rtl/pcvd_div.sv =====
// Restoring radix-2 divider, 64-bit dividend and divisor, one quotient bit per cycle.
// Depends on pcvd_pkg.
module pcvd_div (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  n_i,
  input  logic [63:0]  d_i,
  output logic         done_o,
  output logic [63:0]  q_o,
  output logic [63:0]  r_o
);
  import pcvd_pkg::*;

  logic [63:0]     r_q, nq_q, d_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [64:0]     shifted;
  logic [65:0]     diff;
  logic            ge;

  assign shifted = {r_q, nq_q[63]};
  assign diff    = {1'b0, shifted} - {2'b00, d_q};
  assign ge      = !diff[65];
  assign done_o  = done_q;
  assign q_o     = nq_q;
  assign r_o     = r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == '1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q  <= '0;
      nq_q <= n_i;
      d_q  <= d_i;
    end else if (busy_q) begin
      r_q  <= ge ? diff[63:0] : shifted[63:0];
      nq_q <= {nq_q[62:0], ge};
    end
  end
endmodule

// ===== rtl/pcvd_chk.sv =====
// Port-level checks for the PID controller, bound to the top level.
// Depends on pid_controller_variable_dt.
module pcvd_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [pcvd_pkg::DataW-1:0] drive,
  input logic                              clamped
);
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after an item");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without an item in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(clamped))
    else $error("stalled result changed");
endmodule

bind pid_controller_variable_dt pcvd_chk u_pcvd_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .drive     (out_if.drive),
  .clamped   (out_if.clamped)
);
